@@ rtl/assert_macros.svh @@
// Shared assertion macros for the particle lifetime block.
// Each use gives a label, the clock, the active-low reset, a condition and
// the property that must follow from it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the condition (may carry ## delays)
`define PLI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("pli: implication check failed");

// Consequent checked in the cycle after the condition
`define PLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("pli: next-cycle check failed");

`endif

@@ rtl/pli_pkg.sv @@
`timescale 1ns / 1ps

package pli_pkg;

  // Field and datapath widths
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned DataW   = 32;
  localparam int unsigned ScaleW  = 24;
  localparam int unsigned QuoW    = 16;  // fraction bits of t
  localparam int unsigned TW      = 17;  // t including the 1.0 bit
  localparam int unsigned MulAW   = 34;
  localparam int unsigned MulBW   = 18;
  localparam int unsigned MulPW   = MulAW + MulBW;

  // Reset values
  localparam logic [DataW-1:0]  StartColorRst = 32'hFFFF_FFFF;
  localparam logic [DataW-1:0]  EndColorRst   = 32'h0000_0000;
  localparam logic [ScaleW-1:0] StartSizeRst  = 24'h01_0000;
  localparam logic [ScaleW-1:0] EndSizeRst    = 24'h00_0000;
  localparam logic [DataW-1:0]  LifetimeRst   = 32'h0001_0000;
  localparam logic [TW-1:0]     TOne          = 17'h1_0000;

  // Request commands
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_PLACE  = 2'd1,
    CMD_ENABLE = 2'd2
  } pli_cmd_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_COLOR = 3'd0,
    CFG_END_COLOR   = 3'd1,
    CFG_START_SIZE  = 3'd2,
    CFG_END_SIZE    = 3'd3,
    CFG_START_SPEED = 3'd4,
    CFG_END_SPEED   = 3'd5,
    CFG_LIFETIME    = 3'd6,
    CFG_HEADING     = 3'd7
  } pli_cfg_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_CMP,
    ST_DIV,
    ST_MUL,
    ST_WB,
    ST_DONE
  } pli_state_e;

  // Multiply steps of one tick, in issue order
  typedef enum logic [3:0] {
    OP_RED,
    OP_GREEN,
    OP_BLUE,
    OP_ALPHA,
    OP_SCALE,
    OP_SPEED,
    OP_DIRX,
    OP_DIRY,
    OP_XHI,
    OP_XLO,
    OP_YHI,
    OP_YLO
  } pli_op_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [31:0]       step_dt;
    logic signed [31:0] place_x;
    logic signed [31:0] place_y;
  } pli_req_t;

  typedef struct packed {
    logic               alive;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic [23:0]        scale;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } pli_rsp_t;

endpackage

@@ rtl/pli_div.sv @@
`timescale 1ns / 1ps

// Restoring divider: quo = (num << 16) / den, one quotient bit a cycle.
// Requires num < den, so the quotient fits in 16 bits.
module pli_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pli_pkg::DataW-1:0]    num_i,
  input  logic [pli_pkg::DataW-1:0]    den_i,
  output logic                         done_o,
  output logic [pli_pkg::QuoW-1:0]     quo_o
);

  localparam int unsigned CntW = $clog2(pli_pkg::QuoW);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [pli_pkg::DataW-1:0]   rem_q, rem_d;
  logic [pli_pkg::DataW-1:0]   den_q, den_d;
  logic [pli_pkg::QuoW-1:0]    quo_q, quo_d;
  logic [pli_pkg::DataW:0]     shifted;
  logic [pli_pkg::DataW:0]     diff;

  // One trial subtraction per cycle
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quo_d   = quo_q;
    shifted = {rem_q, 1'b0};
    diff    = shifted - {1'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(pli_pkg::QuoW - 1);
      rem_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_d = diff[pli_pkg::DataW-1:0];
        quo_d = {quo_q[pli_pkg::QuoW-2:0], 1'b1};
      end else begin
        rem_d = shifted[pli_pkg::DataW-1:0];
        quo_d = {quo_q[pli_pkg::QuoW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ rtl/pli_mul.sv @@
`timescale 1ns / 1ps

// Shared signed multiplier with a registered product.
module pli_mul (
  input  logic                              clk_i,
  input  logic signed [pli_pkg::MulAW-1:0]  a_i,
  input  logic signed [pli_pkg::MulBW-1:0]  b_i,
  output logic signed [pli_pkg::MulPW-1:0]  p_o
);

  logic signed [pli_pkg::MulPW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

@@ rtl/particle_lifetime_interpolator_core.sv @@
`timescale 1ns / 1ps
// Place, enable, spare and idle-tick requests: the DONE state loads the output register
// once the output slot is empty or not stalled; the next request is taken after that load.
// Active tick: add, compare, serial divider (skipped when the life ends), then 12 steps of
// a MUL and a WB state each on the one shared multiplier, and DONE to load the output
// register.
// rst_ni (async, active low) clears the state and loads the register defaults.
module particle_lifetime_interpolator_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  pli_pkg::pli_req_t                in_req_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output pli_pkg::pli_rsp_t                out_rsp_o,
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pli_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [pli_pkg::DataW-1:0]        cfg_data_i
);

  // Saturate a wide two's complement value to signed 32 bits
  function automatic logic [31:0] sat32(input logic [pli_pkg::MulPW-1:0] v);
    logic [pli_pkg::MulPW-32:0] top;
    top = v[pli_pkg::MulPW-1:31];
    if ((top == '0) || (top == '1)) begin
      return v[31:0];
    end else if (v[pli_pkg::MulPW-1]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7FFF_FFFF;
    end
  endfunction

  // Configuration registers
  logic [31:0] start_color_q, end_color_q;
  logic [23:0] start_size_q, end_size_q;
  logic [31:0] start_speed_q, end_speed_q;
  logic [31:0] lifetime_q, heading_q;

  // Particle state
  logic [31:0] elapsed_q, elapsed_d;
  logic        active_q, active_d;
  logic [31:0] pos_x_q, pos_x_d;
  logic [31:0] pos_y_q, pos_y_d;
  logic [31:0] color_q, color_d;
  logic [23:0] scale_q, scale_d;

  // Sequencer and working registers
  pli_pkg::pli_state_e state_q, state_d;
  pli_pkg::pli_op_e    op_q, op_d;
  logic [pli_pkg::TW-1:0]    t_q, t_d;
  logic [31:0]               dt_q, dt_d;
  logic [31:0]               spd_q, spd_d;
  logic [pli_pkg::MulAW-1:0] dx_q, dx_d;
  logic [pli_pkg::MulAW-1:0] dy_q, dy_d;
  logic [pli_pkg::MulPW-1:0] acc_q, acc_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic              out_load;
  pli_pkg::pli_rsp_t out_q;

  // Shared units
  logic                              div_start;
  logic                              div_done;
  logic [pli_pkg::QuoW-1:0]          div_quo;
  logic signed [pli_pkg::MulAW-1:0]  mul_a;
  logic signed [pli_pkg::MulBW-1:0]  mul_b;
  logic signed [pli_pkg::MulPW-1:0]  mul_p;

  logic [8:0]                        red_diff, green_diff, blue_diff, alpha_diff;
  logic [24:0]                       size_diff;
  logic [32:0]                       speed_diff;
  logic [32:0]                       elapsed_sum;
  logic [pli_pkg::MulPW-1:0]         mul_shr;
  logic [pli_pkg::MulBW-1:0]         t_ext;

  pli_div u_pli_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (elapsed_q),
    .den_i   (lifetime_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  pli_mul u_pli_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // Interpolation spans (end minus start), wrapped to one extra bit
  assign red_diff    = {1'b0, end_color_q[31:24]} - {1'b0, start_color_q[31:24]};
  assign green_diff  = {1'b0, end_color_q[23:16]} - {1'b0, start_color_q[23:16]};
  assign blue_diff   = {1'b0, end_color_q[15:8]}  - {1'b0, start_color_q[15:8]};
  assign alpha_diff  = {1'b0, end_color_q[7:0]}   - {1'b0, start_color_q[7:0]};
  assign size_diff   = {1'b0, end_size_q} - {1'b0, start_size_q};
  assign speed_diff  = {end_speed_q[31], end_speed_q} - {start_speed_q[31], start_speed_q};
  assign elapsed_sum = {1'b0, elapsed_q} + {1'b0, dt_q};
  assign mul_shr     = {{16{mul_p[pli_pkg::MulPW-1]}}, mul_p[pli_pkg::MulPW-1:16]};
  assign t_ext       = {1'b0, t_q};

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_q)
      pli_pkg::OP_RED: begin
        mul_a = {{25{red_diff[8]}}, red_diff};
        mul_b = t_ext;
      end
      pli_pkg::OP_GREEN: begin
        mul_a = {{25{green_diff[8]}}, green_diff};
        mul_b = t_ext;
      end
      pli_pkg::OP_BLUE: begin
        mul_a = {{25{blue_diff[8]}}, blue_diff};
        mul_b = t_ext;
      end
      pli_pkg::OP_ALPHA: begin
        mul_a = {{25{alpha_diff[8]}}, alpha_diff};
        mul_b = t_ext;
      end
      pli_pkg::OP_SCALE: begin
        mul_a = {{9{size_diff[24]}}, size_diff};
        mul_b = t_ext;
      end
      pli_pkg::OP_SPEED: begin
        mul_a = {speed_diff[32], speed_diff};
        mul_b = t_ext;
      end
      pli_pkg::OP_DIRX: begin
        mul_a = {{2{spd_q[31]}}, spd_q};
        mul_b = {{2{heading_q[31]}}, heading_q[31:16]};
      end
      pli_pkg::OP_DIRY: begin
        mul_a = {{2{spd_q[31]}}, spd_q};
        mul_b = {{2{heading_q[15]}}, heading_q[15:0]};
      end
      pli_pkg::OP_XHI: begin
        mul_a = dx_q;
        mul_b = {2'b00, dt_q[31:16]};
      end
      pli_pkg::OP_XLO: begin
        mul_a = dx_q;
        mul_b = {2'b00, dt_q[15:0]};
      end
      pli_pkg::OP_YHI: begin
        mul_a = dy_q;
        mul_b = {2'b00, dt_q[31:16]};
      end
      pli_pkg::OP_YLO: begin
        mul_a = dy_q;
        mul_b = {2'b00, dt_q[15:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer: next state and datapath updates
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    elapsed_d   = elapsed_q;
    active_d    = active_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    color_d     = color_q;
    scale_d     = scale_q;
    t_d         = t_q;
    dt_d        = dt_q;
    spd_d       = spd_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    acc_d       = acc_q;
    div_start   = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      pli_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = pli_pkg::ST_DONE;
          case (in_req_i.cmd)
            pli_pkg::CMD_TICK: begin
              if (active_q) begin
                dt_d    = in_req_i.step_dt;
                state_d = pli_pkg::ST_ADD;
              end
            end
            pli_pkg::CMD_PLACE: begin
              pos_x_d   = in_req_i.place_x;
              pos_y_d   = in_req_i.place_y;
              elapsed_d = '0;
              active_d  = 1'b0;
              color_d   = start_color_q;
              scale_d   = start_size_q;
            end
            pli_pkg::CMD_ENABLE: begin
              active_d = 1'b1;
            end
            default: begin
              active_d = active_q;
            end
          endcase
        end
      end
      pli_pkg::ST_ADD: begin
        // timer saturates at all ones
        elapsed_d = elapsed_sum[32] ? '1 : elapsed_sum[31:0];
        state_d   = pli_pkg::ST_CMP;
      end
      pli_pkg::ST_CMP: begin
        if (elapsed_q >= lifetime_q) begin
          t_d      = pli_pkg::TOne;
          active_d = 1'b0;
          op_d     = pli_pkg::OP_RED;
          state_d  = pli_pkg::ST_MUL;
        end else begin
          div_start = 1'b1;
          state_d   = pli_pkg::ST_DIV;
        end
      end
      pli_pkg::ST_DIV: begin
        if (div_done) begin
          t_d     = {1'b0, div_quo};
          op_d    = pli_pkg::OP_RED;
          state_d = pli_pkg::ST_MUL;
        end
      end
      pli_pkg::ST_MUL: begin
        state_d = pli_pkg::ST_WB;
      end
      pli_pkg::ST_WB: begin
        // colour, size, speed: start + floor(product / 2^16); low bits wrap as the result stays in range
        case (op_q)
          pli_pkg::OP_RED:   color_d[31:24] = start_color_q[31:24] + mul_p[23:16];
          pli_pkg::OP_GREEN: color_d[23:16] = start_color_q[23:16] + mul_p[23:16];
          pli_pkg::OP_BLUE:  color_d[15:8]  = start_color_q[15:8]  + mul_p[23:16];
          pli_pkg::OP_ALPHA: color_d[7:0]   = start_color_q[7:0]   + mul_p[23:16];
          pli_pkg::OP_SCALE: scale_d = start_size_q + mul_p[39:16];
          pli_pkg::OP_SPEED: spd_d   = start_speed_q + mul_p[47:16];
          pli_pkg::OP_DIRX:  dx_d    = mul_p[47:14];
          pli_pkg::OP_DIRY:  dy_d    = mul_p[47:14];
          pli_pkg::OP_XHI:   acc_d   = {{20{pos_x_q[31]}}, pos_x_q} + mul_p;
          pli_pkg::OP_XLO:   pos_x_d = sat32(acc_q + mul_shr);
          pli_pkg::OP_YHI:   acc_d   = {{20{pos_y_q[31]}}, pos_y_q} + mul_p;
          pli_pkg::OP_YLO:   pos_y_d = sat32(acc_q + mul_shr);
          default:           acc_d   = acc_q;
        endcase
        if (op_q == pli_pkg::OP_YLO) begin
          state_d = pli_pkg::ST_DONE;
        end else begin
          op_d    = pli_pkg::pli_op_e'(op_q + 4'd1);
          state_d = pli_pkg::ST_MUL;
        end
      end
      pli_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = pli_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pli_pkg::ST_IDLE;
      end
    endcase
  end

  // Output slot occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and particle state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pli_pkg::ST_IDLE;
      op_q        <= pli_pkg::OP_RED;
      elapsed_q   <= '0;
      active_q    <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      color_q     <= pli_pkg::StartColorRst;
      scale_q     <= pli_pkg::StartSizeRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      elapsed_q   <= elapsed_d;
      active_q    <= active_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      color_q     <= color_d;
      scale_q     <= scale_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk_i) begin
    t_q   <= t_d;
    dt_q  <= dt_d;
    spd_q <= spd_d;
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    acc_q <= acc_d;
    if (out_load) begin
      out_q.alive <= active_q;
      out_q.red   <= color_q[31:24];
      out_q.green <= color_q[23:16];
      out_q.blue  <= color_q[15:8];
      out_q.alpha <= color_q[7:0];
      out_q.scale <= scale_q;
      out_q.pos_x <= pos_x_q;
      out_q.pos_y <= pos_y_q;
    end
  end

  // Configuration register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_color_q <= pli_pkg::StartColorRst;
      end_color_q   <= pli_pkg::EndColorRst;
      start_size_q  <= pli_pkg::StartSizeRst;
      end_size_q    <= pli_pkg::EndSizeRst;
      start_speed_q <= '0;
      end_speed_q   <= '0;
      lifetime_q    <= pli_pkg::LifetimeRst;
      heading_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (pli_pkg::pli_cfg_e'(cfg_index_i))
        pli_pkg::CFG_START_COLOR: start_color_q <= cfg_data_i;
        pli_pkg::CFG_END_COLOR:   end_color_q   <= cfg_data_i;
        pli_pkg::CFG_START_SIZE:  start_size_q  <= cfg_data_i[23:0];
        pli_pkg::CFG_END_SIZE:    end_size_q    <= cfg_data_i[23:0];
        pli_pkg::CFG_START_SPEED: start_speed_q <= cfg_data_i;
        pli_pkg::CFG_END_SPEED:   end_speed_q   <= cfg_data_i;
        pli_pkg::CFG_LIFETIME:    lifetime_q    <= cfg_data_i;
        pli_pkg::CFG_HEADING:     heading_q     <= cfg_data_i;
        default:                  heading_q     <= heading_q;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != pli_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

@@ rtl/pli_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Port-level checks on the particle lifetime block.
module pli_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input pli_pkg::pli_req_t in_req_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input pli_pkg::pli_rsp_t out_rsp_o
);

  // a taken request keeps the block busy for at least the next cycle
  `PLI_ASSERT_NEXT(busy_after_req_a, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // a stalled result stays offered and unchanged
  `PLI_ASSERT_NEXT(out_hold_a, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `PLI_ASSERT_NEXT(out_stable_a, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_rsp_o))

  // place with an empty output slot: inactive result carrying the new x, through the DONE state and the output register
  `PLI_ASSERT_IMP(place_echo_a, clk_i, rst_ni, in_valid_i && !in_stall_o && !out_valid_o && (in_req_i.cmd == pli_pkg::CMD_PLACE), ##2 (out_valid_o && !out_rsp_o.alive && (out_rsp_o.pos_x == $past(in_req_i.place_x, 2))))

endmodule

bind particle_lifetime_interpolator_core pli_checker u_pli_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  // Spare command code: the block ignores it and only reports the state
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam longint PosMax = 64'sd2147483647;
  localparam longint PosMin = -64'sd2147483648;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid_i = 1'b0;
  logic in_stall_o;
  pli_pkg::pli_req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  pli_pkg::pli_rsp_t out_rsp_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [pli_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [pli_pkg::DataW-1:0] cfg_data_i = '0;

  particle_lifetime_interpolator_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Own copy of the registers, at their reset values
  logic [31:0] c_start_color = pli_pkg::StartColorRst;
  logic [31:0] c_end_color = pli_pkg::EndColorRst;
  logic [23:0] c_start_size = pli_pkg::StartSizeRst;
  logic [23:0] c_end_size = pli_pkg::EndSizeRst;
  logic [31:0] c_start_speed = '0;
  logic [31:0] c_end_speed = '0;
  logic [31:0] c_lifetime = pli_pkg::LifetimeRst;
  logic [31:0] c_heading = '0;

  // Own copy of the particle
  logic [31:0] p_elapsed = '0;
  logic p_active = 1'b0;
  logic signed [31:0] p_x = '0;
  logic signed [31:0] p_y = '0;
  logic [31:0] p_color = pli_pkg::StartColorRst;
  logic [23:0] p_scale = pli_pkg::StartSizeRst;

  pli_pkg::pli_req_t request_q[$];
  pli_pkg::pli_rsp_t due_states[$];
  int n_errors = 0;
  int idle_pct = 30;
  logic calm = 1'b0;
  int gap_left = 0;
  int stall_left = 0;

  // Clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Linear blend s + (e - s) * t, floored back to the integer grid
  function automatic longint blend(longint s, longint e, longint t);
    return (s * 65536 + (e - s) * t) >>> 16;
  endfunction

  // Distance along one axis: direction (Q2.14) * speed * elapsed time
  function automatic longint travel(longint dir, longint spd, logic [31:0] dt);
    longint d;
    longint whole;
    longint frac;
    d = (dir * spd * 4) >>> 16;
    whole = longint'(dt[31:16]);
    frac = longint'(dt[15:0]);
    return d * whole + ((d * frac) >>> 16);
  endfunction

  function automatic logic signed [31:0] clamp_add(logic signed [31:0] p, longint d);
    longint r;
    r = p + d;
    if (r > PosMax) r = PosMax;
    if (r < PosMin) r = PosMin;
    return r[31:0];
  endfunction

  // One frame of an active particle
  function automatic void run_tick(logic [31:0] dt);
    logic [32:0] sum;
    logic [47:0] num;
    longint t;
    longint spd;
    longint dx;
    longint dy;
    logic [31:0] col;
    if (!p_active) return;
    sum = {1'b0, p_elapsed} + {1'b0, dt};
    p_elapsed = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    // t saturates at 1.0 and the life ends there; no divide in that case
    if (p_elapsed >= c_lifetime) begin
      t = longint'(pli_pkg::TOne);
      p_active = 1'b0;
    end else begin
      num = {p_elapsed, 16'd0};
      t = longint'(num / c_lifetime);
    end
    for (int k = 0; k < 4; k++) begin
      col[k*8 +: 8] = 8'(blend(longint'(c_start_color[k*8 +: 8]),
                               longint'(c_end_color[k*8 +: 8]), t));
    end
    p_color = col;
    p_scale = 24'(blend(longint'(c_start_size), longint'(c_end_size), t));
    spd = blend(longint'(signed'(c_start_speed)), longint'(signed'(c_end_speed)), t);
    dx = longint'(signed'(c_heading[31:16]));
    dy = longint'(signed'(c_heading[15:0]));
    p_x = clamp_add(p_x, travel(dx, spd, dt));
    p_y = clamp_add(p_y, travel(dy, spd, dt));
  endfunction

  // Apply one request to the particle and return the state it reports
  function automatic pli_pkg::pli_rsp_t advance_particle(pli_pkg::pli_req_t rq);
    pli_pkg::pli_rsp_t rsp;
    case (rq.cmd)
      pli_pkg::CMD_TICK: begin
        run_tick(rq.step_dt);
      end
      pli_pkg::CMD_PLACE: begin
        p_x = rq.place_x;
        p_y = rq.place_y;
        p_elapsed = '0;
        p_active = 1'b0;
        p_color = c_start_color;
        p_scale = c_start_size;
      end
      pli_pkg::CMD_ENABLE: begin
        p_active = 1'b1;
      end
      default: ;
    endcase
    rsp.alive = p_active;
    rsp.red = p_color[31:24];
    rsp.green = p_color[23:16];
    rsp.blue = p_color[15:8];
    rsp.alpha = p_color[7:0];
    rsp.scale = p_scale;
    rsp.pos_x = p_x;
    rsp.pos_y = p_y;
    return rsp;
  endfunction

  function automatic void note_register(pli_pkg::pli_cfg_e idx, logic [31:0] v);
    case (idx)
      pli_pkg::CFG_START_COLOR: c_start_color = v;
      pli_pkg::CFG_END_COLOR:   c_end_color = v;
      pli_pkg::CFG_START_SIZE:  c_start_size = v[23:0];
      pli_pkg::CFG_END_SIZE:    c_end_size = v[23:0];
      pli_pkg::CFG_START_SPEED: c_start_speed = v;
      pli_pkg::CFG_END_SPEED:   c_end_speed = v;
      pli_pkg::CFG_LIFETIME:    c_lifetime = v;
      pli_pkg::CFG_HEADING:     c_heading = v;
      default: ;
    endcase
  endfunction

  task automatic flag_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  task automatic check_state(pli_pkg::pli_rsp_t got);
    pli_pkg::pli_rsp_t want;
    if (due_states.size() == 0) begin
      flag_mismatch($sformatf("result with nothing outstanding: %h", got));
    end else begin
      want = due_states.pop_front();
      compare_field("alive", 32'(got.alive), 32'(want.alive));
      compare_field("red", 32'(got.red), 32'(want.red));
      compare_field("green", 32'(got.green), 32'(want.green));
      compare_field("blue", 32'(got.blue), 32'(want.blue));
      compare_field("alpha", 32'(got.alpha), 32'(want.alpha));
      compare_field("scale", 32'(got.scale), 32'(want.scale));
      compare_field("pos_x", got.pos_x, want.pos_x);
      compare_field("pos_y", got.pos_y, want.pos_y);
    end
  endtask

  // Request driver: predicts on acceptance, idles in short bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) due_states.push_back(advance_particle(in_req_i));
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
          gap_left = $urandom_range(0, 3);
          in_valid_i <= 1'b0;
        end else if (request_q.size() > 0) begin
          in_valid_i <= 1'b1;
          in_req_i <= request_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_state(out_rsp_o);
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(0, 3);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic push_req(logic [1:0] cmd, logic [31:0] dt, logic [31:0] px,
                          logic [31:0] py);
    pli_pkg::pli_req_t rq;
    rq.cmd = cmd;
    rq.step_dt = dt;
    rq.place_x = px;
    rq.place_y = py;
    request_q.push_back(rq);
  endtask

  // Sender holds off until every outstanding request has been answered
  task automatic wait_until_quiet();
    forever begin
      @(negedge clk_i);
      if (request_q.size() == 0 && !in_valid_i && due_states.size() == 0) break;
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_register(pli_pkg::pli_cfg_e idx, logic [31:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    note_register(idx, v);
    cfg_valid_i <= 1'b0;
  endtask

  // flavour 0: random, 1: low extremes, 2: high extremes
  task automatic load_settings(int flavour);
    logic [31:0] v [8];
    case (flavour)
      1: v = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFF_FFFF,
               32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'h8000_8000};
      2: v = '{32'hFFFF_FFFF, 32'h0, 32'hFF_FFFF, 32'h0,
               32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_7FFF};
      default: begin
        v[0] = $urandom;
        v[1] = $urandom;
        v[2] = $urandom & 32'hFF_FFFF;
        v[3] = $urandom & 32'hFF_FFFF;
        v[4] = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h10_0000) - 32'h8_0000;
        v[5] = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h10_0000) - 32'h8_0000;
        v[6] = ($urandom_range(0, 3) == 0) ? ($urandom | 32'h1)
                                           : $urandom_range(1, 32'h4_0000);
        v[7] = $urandom;
      end
    endcase
    write_register(pli_pkg::CFG_START_COLOR, v[0]);
    write_register(pli_pkg::CFG_END_COLOR, v[1]);
    write_register(pli_pkg::CFG_START_SIZE, v[2]);
    write_register(pli_pkg::CFG_END_SIZE, v[3]);
    write_register(pli_pkg::CFG_START_SPEED, v[4]);
    write_register(pli_pkg::CFG_END_SPEED, v[5]);
    write_register(pli_pkg::CFG_LIFETIME, v[6]);
    write_register(pli_pkg::CFG_HEADING, v[7]);
  endtask

  // Mostly whole lives (place, enable, ticks), with some loose requests
  task automatic queue_lives(int n_items);
    int count;
    int n_ticks;
    logic [31:0] dt_top;
    logic [31:0] px;
    logic [31:0] py;
    count = 0;
    dt_top = (c_lifetime >> 2) + 1;
    while (count < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 1)) begin
          px = $urandom;
          py = $urandom;
        end else begin
          px = $urandom_range(0, 32'hFF_FFFF) - 32'h80_0000;
          py = $urandom_range(0, 32'hFF_FFFF) - 32'h80_0000;
        end
        push_req(pli_pkg::CMD_PLACE, $urandom, px, py);
        push_req(pli_pkg::CMD_ENABLE, $urandom, $urandom, $urandom);
        n_ticks = $urandom_range(1, 12);
        for (int i = 0; i < n_ticks; i++) begin
          if ($urandom_range(0, 7) == 0)
            push_req(pli_pkg::CMD_TICK, $urandom, $urandom, $urandom);
          else
            push_req(pli_pkg::CMD_TICK, $urandom_range(0, dt_top), $urandom, $urandom);
          // occasional re-enable, often after the life has ended
          if ($urandom_range(0, 15) == 0) begin
            push_req(pli_pkg::CMD_ENABLE, $urandom, $urandom, $urandom);
            count++;
          end
        end
        count += n_ticks + 2;
      end else begin
        push_req(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
        count++;
      end
    end
  endtask

  // Stimulus and run control
  initial begin
    int flavours [8] = '{1, 0, 2, 0, 0, 0, 0, 0};
    int idles [8] = '{25, 40, 0, 15, 60, 25, 10, 0};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: inactive tick, spare code, a full life, timer saturation
    push_req(pli_pkg::CMD_TICK, 32'h1234_5678, 32'h0, 32'h0);
    push_req(CMD_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(pli_pkg::CMD_PLACE, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
    push_req(pli_pkg::CMD_ENABLE, 32'h0, 32'h0, 32'h0);
    push_req(pli_pkg::CMD_TICK, 32'h0, 32'h0, 32'h0);
    push_req(pli_pkg::CMD_TICK, 32'h4000, 32'h0, 32'h0);
    push_req(pli_pkg::CMD_TICK, 32'h8000, 32'h0, 32'h0);
    push_req(pli_pkg::CMD_TICK, 32'hFFFF_FFFF, 32'h0, 32'h0);
    push_req(pli_pkg::CMD_TICK, 32'h100, 32'h0, 32'h0);
    push_req(pli_pkg::CMD_ENABLE, 32'h0, 32'h0, 32'h0);
    push_req(pli_pkg::CMD_TICK, 32'h0, 32'h0, 32'h0);
    wait_until_quiet();

    // Full-scale speeds and the longest life: position saturation both ways
    write_register(pli_pkg::CFG_START_COLOR, 32'h00FF_00FF);
    write_register(pli_pkg::CFG_END_COLOR, 32'hFF00_FF00);
    write_register(pli_pkg::CFG_START_SIZE, 32'hFF_FFFF);
    write_register(pli_pkg::CFG_START_SPEED, 32'h7FFF_FFFF);
    write_register(pli_pkg::CFG_END_SPEED, 32'h8000_0000);
    write_register(pli_pkg::CFG_LIFETIME, 32'hFFFF_FFFF);
    write_register(pli_pkg::CFG_HEADING, 32'h4000_C000);
    push_req(pli_pkg::CMD_PLACE, 32'h0, 32'h7FFF_0000, 32'h8001_0000);
    push_req(pli_pkg::CMD_ENABLE, 32'h0, 32'h0, 32'h0);
    push_req(pli_pkg::CMD_TICK, 32'h0001_0000, 32'h0, 32'h0);
    push_req(pli_pkg::CMD_TICK, 32'h9000_0000, 32'h0, 32'h0);
    push_req(pli_pkg::CMD_TICK, 32'h9000_0000, 32'h0, 32'h0);
    push_req(pli_pkg::CMD_PLACE, 32'h0, 32'h0, 32'h0);
    push_req(pli_pkg::CMD_ENABLE, 32'h0, 32'h0, 32'h0);
    push_req(pli_pkg::CMD_TICK, 32'h8000_0000, 32'h0, 32'h0);
    wait_until_quiet();

    // Zero lifetime: the first tick ends the life without a divide
    write_register(pli_pkg::CFG_LIFETIME, 32'h0);
    push_req(pli_pkg::CMD_PLACE, 32'h0, 32'h0001_0000, 32'hFFFF_0000);
    push_req(pli_pkg::CMD_ENABLE, 32'h0, 32'h0, 32'h0);
    push_req(pli_pkg::CMD_TICK, 32'h0, 32'h0, 32'h0);
    push_req(pli_pkg::CMD_TICK, 32'h0001_0000, 32'h0, 32'h0);
    wait_until_quiet();

    // Random lives under a sequence of settings
    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = idles[ph];
      calm = (ph == 7);
      load_settings(flavours[ph]);
      queue_lives(166);
      wait_until_quiet();
    end

    repeat (10) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("particle_lifetime_interpolator_core regression: pass");
    end else begin
      $display("particle_lifetime_interpolator_core regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("particle_lifetime_interpolator_core regression: fail");
    $finish;
  end

endmodule
